FILE: rtl/jvcm_pkg.sv
// ---------------------------------------------------------------------------
// jvcm_pkg
// Types and constants shared by the gamepad velocity command mapper.
// ---------------------------------------------------------------------------
package jvcm_pkg;

  localparam int AxisWidth = 16;
  localparam int VelWidth  = 16;
  localparam int NumRegs   = 7;
  localparam int CfgIdxWidth = 3;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegLinScale  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegAngScale  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegLinLimit  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegAngLimit  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegVertLimit = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegCurvRatio = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegTrigMode  = 3'd6;

  localparam logic signed [17:0] HalfQ14 = 18'sd8192;
  localparam logic signed [17:0] OneQ14  = 18'sd16384;

  // quotient bits produced by the curvature divider
  localparam int DivBits = 24;

  typedef struct packed {
    logic signed [15:0] forward_axis;
    logic signed [15:0] reverse_axis;
    logic signed [15:0] ascend_axis;
    logic signed [15:0] descend_axis;
    logic signed [15:0] strafe_left_axis;
    logic signed [15:0] strafe_right_axis;
    logic signed [15:0] turn_axis;
    logic [6:0]         buttons;
  } in_item_t;

  typedef struct packed {
    logic               kill;
    logic               function_one;
    logic               function_two;
    logic               command_valid;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [15:0] velocity_z;
    logic signed [15:0] turn_rate;
  } out_item_t;

  typedef struct packed {
    logic [15:0] linear_scale;
    logic [15:0] angular_scale;
    logic [14:0] linear_limit;
    logic [14:0] angular_limit;
    logic [14:0] vertical_limit;
    logic [15:0] curvature_ratio_min;
    logic [2:0]  trigger_pair_mode;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic calc;      // scale all axes, limit y and z (and x in trigger mode), update state
    logic div_start; // begin curvature divide
    logic div_step;  // one divide iteration
    logic finish;    // apply turn limit in trigger mode, form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
  } dp_sts_t;

  // Round |v|*gain to Q8.8, ties away from zero. v is 18 bit signed.
  function automatic logic signed [19:0] scale_q88(input logic signed [17:0] v,
                                                    input logic [15:0] gain);
    logic        neg;
    logic [17:0] mag;
    logic [33:0] prod;
    logic [19:0] q;
    begin
      neg  = v[17];
      mag  = neg ? 18'(-v) : 18'(v);
      prod = 34'(mag) * 34'(gain) + 34'(1 << 17);
      q    = 20'(prod >> 18);
      scale_q88 = neg ? -$signed(q) : $signed(q);
    end
  endfunction

  function automatic logic signed [19:0] limit_speed(input logic signed [19:0] c,
                                                      input logic [15:0] lim);
    logic [19:0] mag;
    begin
      mag = c[19] ? 20'(-c) : 20'(c);
      if (mag >= 20'(lim))
        limit_speed = (c > 0) ? $signed(20'(lim)) : -$signed(20'(lim));
      else
        limit_speed = c;
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    begin
      if (v > 20'sd32767)       sat16 = 16'sh7FFF;
      else if (v < -20'sd32768) sat16 = 16'sh8000;
      else                      sat16 = v[15:0];
    end
  endfunction

endpackage

FILE: rtl/joystick_velocity_command_mapper.sv
// ---------------------------------------------------------------------------
// joystick_velocity_command_mapper
// Maps a gamepad sample to flags and a saturated Q8.8 velocity command.
// ---------------------------------------------------------------------------
// An item is loaded, computed, checked and finished into a result; when the
// curvature limit is active in trigger mode, a restoring divider yields one
// quotient bit per cycle over 24 bits before the finish. One result item per
// input item. A new item may be taken while a result waits in the output
// register; its last step stalls while the previous result waits to enter it.
module joystick_velocity_command_mapper import jvcm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  out_item_t res;
  logic ov;
  logic hold;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_scale        <= 16'd2048;
      cfg.angular_scale       <= 16'd2048;
      cfg.linear_limit        <= 15'd256;
      cfg.angular_limit       <= 15'd512;
      cfg.vertical_limit      <= 15'd128;
      cfg.curvature_ratio_min <= 16'd0;
      cfg.trigger_pair_mode   <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegLinScale:  cfg.linear_scale        <= cfg_data;
        RegAngScale:  cfg.angular_scale       <= cfg_data;
        RegLinLimit:  cfg.linear_limit        <= cfg_data[14:0];
        RegAngLimit:  cfg.angular_limit       <= cfg_data[14:0];
        RegVertLimit: cfg.vertical_limit      <= cfg_data[14:0];
        RegCurvRatio: cfg.curvature_ratio_min <= cfg_data;
        RegTrigMode:  cfg.trigger_pair_mode   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  jvcm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall,
    .out_valid(ov), .out_stall(hold), .sts, .cmd
  );

  jvcm_datapath u_dp (
    .clk, .rst, .cfg, .in_data, .cmd, .sts, .result(res)
  );

  // output register: takes the finished result, frees the sequencer
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ov && !hold) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (ov && !hold) out_data <= res;
  end
  assign hold = out_valid && out_stall;

endmodule

FILE: rtl/jvcm_datapath.sv
// ---------------------------------------------------------------------------
// jvcm_datapath
// Axis scaling, limiting, trigger gating and a bit-serial curvature divider.
// ---------------------------------------------------------------------------
module jvcm_datapath import jvcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t result
);

  in_item_t item;
  logic [5:0] trigger_seen;
  logic       deadman_held;
  logic       valid_r;
  logic signed [19:0] vx, vy, vz, wz;
  logic [14:0] maxw;
  logic        need_div;
  // divider
  logic [DivBits-1:0] quo;
  logic [15:0]        rem;
  logic [23:0]        dividend;

  logic deadman;
  assign deadman = item.buttons[0];

  // trigger gating, combinational on the held item
  logic [5:0] seen_next;
  logic signed [17:0] g_fwd, g_rev, g_asc, g_des, g_lft, g_rgt;

  function automatic logic [17:0] absv(input logic signed [17:0] v);
    absv = v[17] ? 18'(-v) : 18'(v);
  endfunction

  always_comb begin
    logic signed [17:0] raw [6];
    logic signed [17:0] g [6];
    logic [2:0] pm;
    raw[0] = 18'(item.forward_axis);
    raw[1] = 18'(item.reverse_axis);
    raw[2] = 18'(item.ascend_axis);
    raw[3] = 18'(item.descend_axis);
    raw[4] = 18'(item.strafe_left_axis);
    raw[5] = 18'(item.strafe_right_axis);
    pm = cfg.trigger_pair_mode;
    seen_next = trigger_seen;
    for (int i = 0; i < 6; i++) begin
      g[i] = raw[i];
      if (!trigger_seen[i]) begin
        if (absv(raw[i]) < 18'(HalfQ14)) g[i] = OneQ14;
        else if (deadman && pm[i/2]) seen_next[i] = 1'b1;
      end
    end
    g_fwd = g[0]; g_rev = g[1]; g_asc = g[2];
    g_des = g[3]; g_lft = g[4]; g_rgt = g[5];
  end

  // pair selection and scaling
  logic signed [19:0] vx_c, vy_c, vz_c, wz_c;
  always_comb begin
    wz_c = scale_q88(18'(item.turn_axis), cfg.angular_scale);
    if (!cfg.trigger_pair_mode[0])
      vx_c = scale_q88(18'(item.forward_axis), cfg.linear_scale);
    else
      vx_c = limit_speed(scale_q88(18'(g_rev - g_fwd), cfg.linear_scale),
                         16'(cfg.linear_limit));
    if (!cfg.trigger_pair_mode[1])
      vz_c = limit_speed(scale_q88(18'(item.ascend_axis), cfg.linear_scale),
                         16'(cfg.vertical_limit));
    else
      vz_c = limit_speed(scale_q88(18'(g_des - g_asc), cfg.linear_scale),
                         16'(cfg.vertical_limit));
    if (!cfg.trigger_pair_mode[2])
      vy_c = limit_speed(scale_q88(18'(item.strafe_left_axis), cfg.linear_scale),
                         16'(cfg.linear_limit));
    else
      vy_c = limit_speed(scale_q88(18'(g_rgt - g_lft), cfg.linear_scale),
                         16'(cfg.linear_limit));
  end

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  assign rem_sh  = {rem, dividend[DivBits-1]};
  assign rem_sub = rem_sh - 17'(cfg.curvature_ratio_min);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_seen <= '0;
      deadman_held <= 1'b0;
    end else if (cmd.calc) begin
      trigger_seen <= seen_next;
      deadman_held <= deadman;
    end
    if (cmd.load) item <= in_data;
    if (cmd.calc) begin
      valid_r  <= deadman | deadman_held;
      need_div <= deadman && cfg.trigger_pair_mode[0] &&
                  !(item.buttons[5] && item.buttons[6]) &&
                  (cfg.curvature_ratio_min != 16'd0);
      if (deadman) begin
        vx <= vx_c; vy <= vy_c; vz <= vz_c; wz <= wz_c;
      end else begin
        vx <= '0; vy <= '0; vz <= '0; wz <= '0;
      end
      maxw <= cfg.angular_limit;
    end
    if (cmd.div_start) begin
      dividend <= {(vx[19] ? 16'(-vx) : 16'(vx)), 8'd0};
      rem      <= '0;
      quo      <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[DivBits-2:0], 1'b0};
      // remainder stays below the divisor, so 16 bits hold it
      if (!rem_sub[16] && rem_sh >= 17'(cfg.curvature_ratio_min)) begin
        rem <= rem_sub[15:0];
        quo <= {quo[DivBits-2:0], 1'b1};
      end else begin
        rem <= rem_sh[15:0];
        quo <= {quo[DivBits-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      result.kill          <= item.buttons[3] & item.buttons[4];
      result.function_one  <= item.buttons[1] & item.buttons[0];
      result.function_two  <= item.buttons[2];
      result.command_valid <= valid_r;
      result.velocity_x    <= sat16(vx);
      result.velocity_y    <= sat16(vy);
      result.velocity_z    <= sat16(vz);
      if (deadman && cfg.trigger_pair_mode[0]) begin
        if (need_div && quo < DivBits'(maxw))
          result.turn_rate <= sat16(limit_speed(wz, 16'(quo)));
        else
          result.turn_rate <= sat16(limit_speed(wz, 16'(maxw)));
      end else
        result.turn_rate <= sat16(wz);
    end
  end

  assign sts.need_div = need_div;

endmodule

FILE: rtl/jvcm_ctrl.sv
// ---------------------------------------------------------------------------
// jvcm_ctrl
// Sequencer: load, compute, optional divide, deliver result item.
// ---------------------------------------------------------------------------
module jvcm_ctrl import jvcm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_CHECK, S_DIV, S_FIN} state_t;
  state_t state;
  logic [4:0] cnt;
  logic       res_free;

  assign in_stall = (state != S_IDLE);

  // result register may be overwritten once its item has moved on
  assign res_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.calc      = (state == S_CALC);
    cmd.div_start = (state == S_CHECK);
    cmd.div_step  = (state == S_DIV);
    cmd.finish    = (state == S_FIN) && res_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_CALC;
        S_CALC:  state <= S_CHECK;
        S_CHECK: begin
          cnt   <= '0;
          state <= sts.need_div ? S_DIV : S_FIN;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DivBits - 1)) state <= S_FIN;
        end
        // wait here while the previous result is still held
        S_FIN: begin
          if (res_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/jvcm_checker.sv
// ---------------------------------------------------------------------------
// jvcm_checker
// Port-level checks for the command mapper.
// ---------------------------------------------------------------------------
module jvcm_checker import jvcm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // no x velocity or turn rate without a command
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.command_valid |-> out_data.velocity_x == 16'sd0 &&
    out_data.turn_rate == 16'sd0)
    else $error("velocity without command");

  // function one needs deadman, so it implies a command
  a_f1: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.function_one |-> out_data.command_valid)
    else $error("function one without command");

  // an accepted item blocks further input next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind joystick_velocity_command_mapper jvcm_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
